>>> design/lsoa_pkg.sv
// Shared types, constants and helper functions for the light-seeking steering block.
package lsoa_pkg;

    // Fixed field widths.
    localparam int RANGE_W = 11;
    localparam int LIGHT_W = 12;
    localparam int SPEED_W = 13;
    localparam int LEVEL_W = 12;
    localparam int BLINK_W = 8;
    localparam int LED_W   = 2;

    // Modifier and weighted-sum arithmetic. FIVE_W also holds 4 * FULL_SCALE at the
    // largest full scale.
    localparam int FIVE_W   = 16;
    localparam int MOD_W    = 14;
    localparam int WEIGHT_W = 10;
    localparam int PROD_W   = MOD_W + WEIGHT_W;
    localparam int SUM_W    = 21;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int TABLE_DEPTH = 16;
    localparam int TABLE_IDX_W = 4;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef enum logic [2:0] {
        CFG_TURN_THRESHOLD = 3'd0,
        CFG_LIGHT_MARGIN   = 3'd1,
        CFG_TRACK_LEVEL    = 3'd2,
        CFG_GOAL_LEVEL     = 3'd3,
        CFG_BLINK_PERIOD   = 3'd4,
        CFG_TOP_SPEED      = 3'd5
    } cfg_index_t;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_TURN_THRESHOLD = 12'd100;
    localparam logic [LEVEL_W-1:0] RST_LIGHT_MARGIN   = 12'd5;
    localparam logic [LEVEL_W-1:0] RST_TRACK_LEVEL    = 12'd600;
    localparam logic [LEVEL_W-1:0] RST_GOAL_LEVEL     = 12'd890;
    localparam logic [BLINK_W-1:0] RST_BLINK_PERIOD   = 8'd70;
    localparam logic [LEVEL_W-1:0] RST_TOP_SPEED      = 12'd2125;

    // Heading state machine, one-hot.
    typedef enum logic [2:0] {
        HEAD_FWD   = 3'b001,
        HEAD_LEFT  = 3'b010,
        HEAD_RIGHT = 3'b100
    } heading_t;

    // Fixed light-tracking turn speeds, Q8 (-1.5 and 3.0 rad/s).
    localparam logic signed [SPEED_W-1:0] TRACK_BACK = -13'sd384;
    localparam logic signed [SPEED_W-1:0] TRACK_FWD  = 13'sd768;

    localparam logic [LED_W-1:0] LED_LAST = 2'd2;

    localparam logic [3:0] TENTHS_9 = 4'd9;
    localparam logic [3:0] TENTHS_8 = 4'd8;

    // Per-sensor obstacle weights.
    function automatic logic [WEIGHT_W-1:0] weight_left(input logic [TABLE_IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            4'd0:    w = 10'd150;
            4'd1:    w = 10'd200;
            4'd2:    w = 10'd300;
            4'd3:    w = 10'd600;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_right(input logic [TABLE_IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            4'd4:    w = 10'd600;
            4'd5:    w = 10'd300;
            4'd6:    w = 10'd200;
            4'd7:    w = 10'd150;
            default: w = 10'd0;
        endcase
        return w;
    endfunction

    // Fraction of the top speed in tenths, rounded half up. The divide by ten is a
    // multiply by the reciprocal 52429 / 2^19, exact for the 16-bit values here.
    function automatic logic [LEVEL_W-1:0] scale_tenths(input logic [LEVEL_W-1:0] top,
                                                        input logic [3:0] tenths);
        logic [15:0] scaled;
        logic [31:0] recip;
        scaled = 16'(top * tenths) + 16'd5;
        recip  = 32'(scaled) * 32'd52429;
        return recip[19 +: LEVEL_W];
    endfunction

endpackage

>>> design/lsoa_in_if.sv
// Input channel carrying one distance reading and the light samples per item.
interface lsoa_in_if;
    import lsoa_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_reading;
    logic               last_reading;
    logic [LIGHT_W-1:0] light_left;
    logic [LIGHT_W-1:0] light_right;

    modport source (output valid, output range_reading, output last_reading,
                    output light_left, output light_right, input ready);
    modport sink   (input valid, input range_reading, input last_reading,
                    input light_left, input light_right, output ready);
endinterface

>>> design/lsoa_out_if.sv
// Output channel carrying one steering command per item.
interface lsoa_out_if;
    import lsoa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      goal_reached;
    logic [LED_W-1:0]          lit_led;
    logic                      led_active;

    modport source (output valid, output left_speed, output right_speed,
                    output goal_reached, output lit_led, output led_active, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input goal_reached, input lit_led, input led_active, output ready);
endinterface

>>> design/light_seek_obstacle_avoid_steering.sv
// Steering core: obstacle weighting, light tracking, heading machine and LED blinker.
//
// Usage. Each control tick the sensor channel delivers one item per distance
// sensor, in sensor order; the item with last_reading set closes the tick and
// carries the two light samples. The sensor index is kept internally and
// restarts after every closing item. Only a closing item produces an item on
// the steering channel, with both wheel speeds, the goal flag and LED status.
// An accepted item is registered in the input stage and processed in stage
// two; a closing item's result is registered for the steering channel.
// Throughput is one item per cycle but for the stall below; the limiting path
// is the weight multiply, saturating accumulate and threshold compare in stage
// two. The sensor channel keeps accepting while a result waits on the steering
// channel; it only stops when a closing item is held in the input stage behind
// a result that the receiver has not yet taken, so a stalled receiver never
// loses or repeats a result. Reset (rst_n low) clears both stages, the sums,
// the heading (forward), the blinker, the goal latch, and loads the
// configuration registers with their defaults. The user must write configuration
// over the APB port only while the block is idle; the block does not enforce it.
module light_seek_obstacle_avoid_steering
    import lsoa_pkg::*;
#(
    parameter int NUM_SENSORS = 16,
    parameter int FULL_SCALE  = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lsoa_in_if.sink               sensor_in,
    lsoa_out_if.source            steer_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SLOT_W = $clog2(NUM_SENSORS + 1);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(NUM_SENSORS);
    localparam logic [FIVE_W-1:0] MOD_BASE = FIVE_W'(4 * FULL_SCALE);
    localparam int LIM_W = LEVEL_W + $clog2(FULL_SCALE + 1);
    localparam logic [LIM_W-1:0] FS_L = LIM_W'(FULL_SCALE);
    localparam int CMP_W = (LIM_W > SUM_W) ? LIM_W : SUM_W;
    localparam logic [LIM_W-1:0] RST_LIMIT = LIM_W'(100 * FULL_SCALE);
    localparam logic [LEVEL_W-1:0] RST_P9 = scale_tenths(RST_TOP_SPEED, TENTHS_9);
    localparam logic [LEVEL_W-1:0] RST_P8 = scale_tenths(RST_TOP_SPEED, TENTHS_8);

    // Configuration registers. The obstacle limit and the 0.9 / 0.8 speeds are
    // derived when the register is written, so the datapath only compares.
    logic [LEVEL_W-1:0] turn_threshold_reg;
    logic [LEVEL_W-1:0] light_margin_reg;
    logic [LEVEL_W-1:0] track_level_reg;
    logic [LEVEL_W-1:0] goal_level_reg;
    logic [BLINK_W-1:0] blink_period_reg;
    logic [LEVEL_W-1:0] top_speed_reg;
    logic [LIM_W-1:0]   limit_reg;
    logic [LEVEL_W-1:0] p9_reg;
    logic [LEVEL_W-1:0] p8_reg;

    logic       cfg_write;
    cfg_index_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = cfg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_threshold_reg <= RST_TURN_THRESHOLD;
            light_margin_reg   <= RST_LIGHT_MARGIN;
            track_level_reg    <= RST_TRACK_LEVEL;
            goal_level_reg     <= RST_GOAL_LEVEL;
            blink_period_reg   <= RST_BLINK_PERIOD;
            top_speed_reg      <= RST_TOP_SPEED;
            limit_reg          <= RST_LIMIT;
            p9_reg             <= RST_P9;
            p8_reg             <= RST_P8;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                CFG_TURN_THRESHOLD:
                begin
                    turn_threshold_reg <= pwdata[LEVEL_W-1:0];
                    limit_reg          <= LIM_W'(pwdata[LEVEL_W-1:0]) * FS_L;
                end
                CFG_LIGHT_MARGIN: light_margin_reg <= pwdata[LEVEL_W-1:0];
                CFG_TRACK_LEVEL:  track_level_reg  <= pwdata[LEVEL_W-1:0];
                CFG_GOAL_LEVEL:   goal_level_reg   <= pwdata[LEVEL_W-1:0];
                CFG_BLINK_PERIOD: blink_period_reg <= pwdata[BLINK_W-1:0];
                CFG_TOP_SPEED:
                begin
                    top_speed_reg <= pwdata[LEVEL_W-1:0];
                    p9_reg        <= scale_tenths(pwdata[LEVEL_W-1:0], TENTHS_9);
                    p8_reg        <= scale_tenths(pwdata[LEVEL_W-1:0], TENTHS_8);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_TURN_THRESHOLD: prdata = APB_DATA_W'(turn_threshold_reg);
            CFG_LIGHT_MARGIN:   prdata = APB_DATA_W'(light_margin_reg);
            CFG_TRACK_LEVEL:    prdata = APB_DATA_W'(track_level_reg);
            CFG_GOAL_LEVEL:     prdata = APB_DATA_W'(goal_level_reg);
            CFG_BLINK_PERIOD:   prdata = APB_DATA_W'(blink_period_reg);
            CFG_TOP_SPEED:      prdata = APB_DATA_W'(top_speed_reg);
            default:            prdata = '0;
        endcase
    end

    // Stage one: input register.
    logic               s1_valid_reg;
    logic [RANGE_W-1:0] s1_range_reg;
    logic               s1_last_reg;
    logic [LIGHT_W-1:0] s1_light_l_reg;
    logic [LIGHT_W-1:0] s1_light_r_reg;

    // Stage two state.
    heading_t           heading_reg, heading_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SUM_W-1:0]   lsum_reg, lsum_next;
    logic [SUM_W-1:0]   rsum_reg, rsum_next;
    logic [BLINK_W-1:0] blink_reg, blink_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic               led_started_reg, led_started_next;
    logic               goal_reg, goal_next;

    // Result register.
    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] out_left_reg, out_left_next;
    logic signed [SPEED_W-1:0] out_right_reg, out_right_next;
    logic                      out_goal_reg;
    logic [LED_W-1:0]          out_led_reg;
    logic                      out_active_reg;

    logic out_free;
    logic s2_go;
    logic s2_emit;
    logic in_take;

    // A closing item may only leave stage two when the result register can take it.
    assign out_free = !out_valid_reg || steer_out.ready;
    assign s2_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign s2_emit  = s2_go && s1_last_reg;
    assign sensor_in.ready = !s1_valid_reg || s2_go;
    assign in_take  = sensor_in.valid && sensor_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sensor_in.ready)
        begin
            s1_valid_reg <= sensor_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_range_reg   <= sensor_in.range_reading;
            s1_last_reg    <= sensor_in.last_reading;
            s1_light_l_reg <= sensor_in.light_left;
            s1_light_r_reg <= sensor_in.light_right;
        end
    end

    // Stage two datapath: modifier, weighting and saturating accumulation.
    logic [FIVE_W-1:0]  five_v;
    logic [MOD_W-1:0]   modifier;
    logic               slot_open;
    logic [PROD_W-1:0]  prod_l, prod_r;
    logic [PROD_W:0]    acc_l, acc_r;
    logic [SUM_W-1:0]   lsum_upd, rsum_upd;
    logic               obst_l, obst_r;
    logic [LIGHT_W:0]   lr_plus_margin, ll_plus_margin;
    logic               track_left, track_right, goal_seen;
    logic [BLINK_W-1:0] blink_inc;

    always_comb
    begin
        five_v    = FIVE_W'(s1_range_reg) * FIVE_W'(5);
        modifier  = (five_v > MOD_BASE) ? MOD_W'(five_v - MOD_BASE) : '0;
        slot_open = slot_reg < SLOT_LIMIT;
        prod_l    = PROD_W'(modifier) * PROD_W'(weight_left(slot_reg[TABLE_IDX_W-1:0]));
        prod_r    = PROD_W'(modifier) * PROD_W'(weight_right(slot_reg[TABLE_IDX_W-1:0]));
        acc_l     = (PROD_W + 1)'(lsum_reg) + (PROD_W + 1)'(prod_l);
        acc_r     = (PROD_W + 1)'(rsum_reg) + (PROD_W + 1)'(prod_r);
        if (slot_open)
        begin
            lsum_upd = (acc_l > (PROD_W + 1)'(SUM_MAX)) ? SUM_MAX : acc_l[SUM_W-1:0];
            rsum_upd = (acc_r > (PROD_W + 1)'(SUM_MAX)) ? SUM_MAX : acc_r[SUM_W-1:0];
        end
        else
        begin
            lsum_upd = lsum_reg;
            rsum_upd = rsum_reg;
        end

        obst_l = CMP_W'(lsum_upd) > CMP_W'(limit_reg);
        obst_r = CMP_W'(rsum_upd) > CMP_W'(limit_reg);

        ll_plus_margin = (LIGHT_W + 1)'(s1_light_l_reg) + (LIGHT_W + 1)'(light_margin_reg);
        lr_plus_margin = (LIGHT_W + 1)'(s1_light_r_reg) + (LIGHT_W + 1)'(light_margin_reg);
        track_left  = ((LIGHT_W + 1)'(s1_light_l_reg) > lr_plus_margin)
                      && (s1_light_r_reg > track_level_reg);
        track_right = ((LIGHT_W + 1)'(s1_light_r_reg) > ll_plus_margin)
                      && (s1_light_l_reg > track_level_reg);
        goal_seen   = (s1_light_l_reg > goal_level_reg) && (s1_light_r_reg > goal_level_reg);
        blink_inc   = blink_reg + 8'd1;

        heading_next     = heading_reg;
        blink_next       = blink_reg;
        led_next         = led_reg;
        led_started_next = led_started_reg;
        goal_next        = goal_reg;
        out_left_next    = '0;
        out_right_next   = '0;

        if (!s1_last_reg)
        begin
            slot_next = slot_open ? slot_reg + 1'b1 : slot_reg;
            lsum_next = lsum_upd;
            rsum_next = rsum_upd;
        end
        else
        begin
            // The tick closes: sums and slot restart whatever is decided.
            slot_next = '0;
            lsum_next = '0;
            rsum_next = '0;
            if (goal_reg)
            begin
                out_left_next  = '0;
                out_right_next = '0;
            end
            else if (track_left)
            begin
                out_left_next  = TRACK_BACK;
                out_right_next = TRACK_FWD;
            end
            else if (track_right)
            begin
                out_left_next  = TRACK_FWD;
                out_right_next = TRACK_BACK;
            end
            else if (goal_seen)
            begin
                goal_next = 1'b1;
            end
            else
            begin
                case (heading_reg)
                    HEAD_LEFT:
                    begin
                        if (obst_l || obst_r)
                        begin
                            out_left_next  = SPEED_W'(p8_reg);
                            out_right_next = -SPEED_W'(p9_reg);
                        end
                        else
                        begin
                            out_left_next  = SPEED_W'(top_speed_reg);
                            out_right_next = SPEED_W'(top_speed_reg);
                            heading_next   = HEAD_FWD;
                        end
                    end
                    HEAD_RIGHT:
                    begin
                        if (obst_l || obst_r)
                        begin
                            out_left_next  = -SPEED_W'(p9_reg);
                            out_right_next = SPEED_W'(p9_reg);
                        end
                        else
                        begin
                            out_left_next  = SPEED_W'(top_speed_reg);
                            out_right_next = SPEED_W'(top_speed_reg);
                            heading_next   = HEAD_FWD;
                        end
                    end
                    default:
                    begin
                        if (obst_l)
                        begin
                            out_left_next  = SPEED_W'(p9_reg);
                            out_right_next = -SPEED_W'(p9_reg);
                            heading_next   = HEAD_LEFT;
                        end
                        else if (obst_r)
                        begin
                            out_left_next  = -SPEED_W'(p9_reg);
                            out_right_next = SPEED_W'(p9_reg);
                            heading_next   = HEAD_RIGHT;
                        end
                        else
                        begin
                            out_left_next  = SPEED_W'(top_speed_reg);
                            out_right_next = SPEED_W'(top_speed_reg);
                            heading_next   = HEAD_FWD;
                        end
                    end
                endcase

                // The blinker only runs on ticks decided by the heading machine, not on goal or light-tracking ticks.
                if (blink_inc == blink_period_reg)
                begin
                    blink_next       = '0;
                    led_next         = (led_reg == LED_LAST) ? '0 : led_reg + 1'b1;
                    led_started_next = 1'b1;
                end
                else
                begin
                    blink_next = blink_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg     <= HEAD_FWD;
            slot_reg        <= '0;
            lsum_reg        <= '0;
            rsum_reg        <= '0;
            blink_reg       <= '0;
            led_reg         <= '0;
            led_started_reg <= 1'b0;
            goal_reg        <= 1'b0;
        end
        else if (s2_go)
        begin
            heading_reg     <= heading_next;
            slot_reg        <= slot_next;
            lsum_reg        <= lsum_next;
            rsum_reg        <= rsum_next;
            blink_reg       <= blink_next;
            led_reg         <= led_next;
            led_started_reg <= led_started_next;
            goal_reg        <= goal_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (steer_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_emit)
        begin
            out_left_reg   <= out_left_next;
            out_right_reg  <= out_right_next;
            out_goal_reg   <= goal_next;
            out_led_reg    <= led_next;
            out_active_reg <= led_started_next;
        end
    end

    assign steer_out.valid        = out_valid_reg;
    assign steer_out.left_speed   = out_left_reg;
    assign steer_out.right_speed  = out_right_reg;
    assign steer_out.goal_reached = out_goal_reg;
    assign steer_out.lit_led      = out_led_reg;
    assign steer_out.led_active   = out_active_reg;

endmodule

>>> tb/sv/light_seek_obstacle_avoid_steering_test.sv
// Self-checking testbench for the light-seeking, obstacle-avoiding steering block.
`timescale 1ns / 100ps

module light_seek_obstacle_avoid_steering_test;
    import lsoa_pkg::*;

    // The block is built with its default sizes, so the testbench uses the same ones.
    localparam int NUM_SENSORS   = 16;
    localparam int FULL_SCALE    = 1024;
    localparam int SUM_LIMIT     = 2097151;
    localparam int CFG_REGS      = 6;
    localparam int RESET_CYCLES  = 11;
    // Extra settling time that wait_idle allows after the last command, as a margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // Obstacle weights: the four left sensors steer the left sum and the next four
    // the right sum. Every other sensor slot carries no weight at all.
    localparam int LEFT_GAIN [16]  = '{150, 200, 300, 600, 0, 0, 0, 0,
                                       0, 0, 0, 0, 0, 0, 0, 0};
    localparam int RIGHT_GAIN [16] = '{0, 0, 0, 0, 600, 300, 200, 150,
                                       0, 0, 0, 0, 0, 0, 0, 0};

    // Light patterns offered on the closing item of a tick.
    typedef enum int {
        LIGHTS_RANDOM,
        LIGHTS_TOWARD_LEFT,
        LIGHTS_TOWARD_RIGHT,
        LIGHTS_DARK,
        LIGHTS_NEAR_EQUAL
    } light_mode_t;

    // How the distance readings of a tick are chosen.
    typedef enum int {
        RANGES_CLEAR,
        RANGES_LEFT_OBSTACLE,
        RANGES_RIGHT_OBSTACLE,
        RANGES_WILD,
        RANGES_BOUNDARY
    } range_mode_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_reading;
        logic               last_reading;
        logic [LIGHT_W-1:0] light_left;
        logic [LIGHT_W-1:0] light_right;
    } sensor_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      goal_reached;
        logic [LED_W-1:0]          lit_led;
        logic                      led_active;
    } steer_cmd_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lsoa_in_if  sensor_ch ();
    lsoa_out_if steer_ch ();

    light_seek_obstacle_avoid_steering i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sensor_in (sensor_ch),
        .steer_out (steer_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Items waiting to be offered, and steering commands waiting to come out.
    sensor_item_t pending_items [$];
    steer_cmd_t   expected_cmds [$];
    sensor_item_t offered;
    steer_cmd_t   predicted;

    // Shadow copy of the configuration registers, indexed by register.
    int cfg_shadow [CFG_REGS];

    // Predicted internal state of the steering core.
    heading_t heading;
    int       sensor_slot;
    int       left_sum;
    int       right_sum;
    int       blink_count;
    int       led_index;
    bit       led_on;
    bit       goal_hold;

    int          mismatch_count;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a run that has not finished by the limit has lost or stalled items.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch at %0t: %s", $realtime, what);
    endfunction

    function automatic string cmd_text(input steer_cmd_t c);
        return $sformatf("left %0d right %0d goal %0b led %0d active %0b",
                         c.left_speed, c.right_speed, c.goal_reached, c.lit_led,
                         c.led_active);
    endfunction

    function automatic int saturate_sum(input int total);
        return (total > SUM_LIMIT) ? SUM_LIMIT : total;
    endfunction

    // Predicts the effect of one accepted sensor item. Every item within the sensor slots adds its weighted
    // obstacle modifier to the two sums; only the closing item of a tick makes a
    // steering decision, and that decision is what the function returns.
    function automatic bit predict_steering(input sensor_item_t it, output steer_cmd_t cmd);
        int modifier;
        int light_l;
        int light_r;
        int full;
        int p9;
        int p8;
        int sl;
        int sr;
        bit obst_l;
        bit obst_r;
        cmd = '0;
        sl  = 0;
        sr  = 0;
        if (sensor_slot < NUM_SENSORS)
        begin
            modifier = 5 * int'(it.range_reading) - 4 * FULL_SCALE;
            if (modifier < 0)
                modifier = 0;
            left_sum  = saturate_sum(left_sum + modifier * LEFT_GAIN[sensor_slot]);
            right_sum = saturate_sum(right_sum + modifier * RIGHT_GAIN[sensor_slot]);
            sensor_slot++;
        end
        if (!it.last_reading)
            return 1'b0;

        // The closing reading is already in the sums when they are compared.
        obst_l      = left_sum > cfg_shadow[CFG_TURN_THRESHOLD] * FULL_SCALE;
        obst_r      = right_sum > cfg_shadow[CFG_TURN_THRESHOLD] * FULL_SCALE;
        left_sum    = 0;
        right_sum   = 0;
        sensor_slot = 0;
        light_l     = int'(it.light_left);
        light_r     = int'(it.light_right);

        if (goal_hold)
        begin
            sl = 0;
            sr = 0;
        end
        else if (light_l > light_r + cfg_shadow[CFG_LIGHT_MARGIN] &&
                 light_r > cfg_shadow[CFG_TRACK_LEVEL])
        begin
            sl = -384;
            sr = 768;
        end
        else if (light_r > light_l + cfg_shadow[CFG_LIGHT_MARGIN] &&
                 light_l > cfg_shadow[CFG_TRACK_LEVEL])
        begin
            sl = 768;
            sr = -384;
        end
        else if (light_l > cfg_shadow[CFG_GOAL_LEVEL] && light_r > cfg_shadow[CFG_GOAL_LEVEL])
        begin
            goal_hold = 1'b1;
            sl = 0;
            sr = 0;
        end
        else
        begin
            full = cfg_shadow[CFG_TOP_SPEED];
            p9   = (9 * full + 5) / 10;
            p8   = (8 * full + 5) / 10;
            case (heading)
                HEAD_LEFT:
                begin
                    if (obst_l || obst_r)
                    begin
                        sl = p8;
                        sr = -p9;
                    end
                    else
                    begin
                        sl = full;
                        sr = full;
                        heading = HEAD_FWD;
                    end
                end
                HEAD_RIGHT:
                begin
                    if (obst_l || obst_r)
                    begin
                        sl = -p9;
                        sr = p9;
                    end
                    else
                    begin
                        sl = full;
                        sr = full;
                        heading = HEAD_FWD;
                    end
                end
                default:
                begin
                    if (obst_l)
                    begin
                        sl = p9;
                        sr = -p9;
                        heading = HEAD_LEFT;
                    end
                    else if (obst_r)
                    begin
                        sl = -p9;
                        sr = p9;
                        heading = HEAD_RIGHT;
                    end
                    else
                    begin
                        sl = full;
                        sr = full;
                        heading = HEAD_FWD;
                    end
                end
            endcase
            // The blink counter wraps at 256 and only an exact match advances the LED.
            blink_count = (blink_count + 1) % 256;
            if (blink_count == cfg_shadow[CFG_BLINK_PERIOD])
            begin
                led_index   = (led_index + 1) % 3;
                led_on      = 1'b1;
                blink_count = 0;
            end
        end

        cmd.left_speed   = SPEED_W'(sl);
        cmd.right_speed  = SPEED_W'(sr);
        cmd.goal_reached = goal_hold;
        cmd.lit_led      = LED_W'(led_index);
        cmd.led_active   = led_on;
        return 1'b1;
    endfunction

    // Sensor-side driver. A new item is offered once the previous one has been
    // taken, unless the random sender gap says otherwise; each accepted item is
    // run through the predictor at the edge that accepts it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sensor_ch.valid <= 1'b0;
        end
        else
        begin
            if (sensor_ch.valid && sensor_ch.ready)
            begin
                if (predict_steering(offered, predicted))
                    expected_cmds.push_back(predicted);
            end
            if (!sensor_ch.valid || sensor_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    sensor_ch.range_reading <= offered.range_reading;
                    sensor_ch.last_reading  <= offered.last_reading;
                    sensor_ch.light_left    <= offered.light_left;
                    sensor_ch.light_right   <= offered.light_right;
                    sensor_ch.valid         <= 1'b1;
                end
                else
                begin
                    sensor_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Steering-side monitor. It checks every accepted command against the oldest
    // prediction and drives ready, with random stalls and, on request, one long
    // hold-off that it counts out itself.
    always @(posedge clk)
    begin
        steer_cmd_t got;
        steer_cmd_t want;
        if (!rst_n)
        begin
            steer_ch.ready <= 1'b0;
        end
        else
        begin
            if (steer_ch.valid && steer_ch.ready)
            begin
                got.left_speed   = steer_ch.left_speed;
                got.right_speed  = steer_ch.right_speed;
                got.goal_reached = steer_ch.goal_reached;
                got.lit_led      = steer_ch.lit_led;
                got.led_active   = steer_ch.led_active;
                if (expected_cmds.size() == 0)
                begin
                    note_mismatch($sformatf("steering item with none expected: %s",
                                            cmd_text(got)));
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (got.left_speed !== want.left_speed ||
                        got.right_speed !== want.right_speed ||
                        got.goal_reached !== want.goal_reached ||
                        got.lit_led !== want.lit_led ||
                        got.led_active !== want.led_active)
                        note_mismatch($sformatf("steering item expected %s, got %s",
                                                cmd_text(want), cmd_text(got)));
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                steer_ch.ready <= 1'b0;
            end
            else
            begin
                steer_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // One register transfer: a setup phase, then an access phase that completes on
    // the edge at which pready is seen high.
    task automatic apb_transfer(input bit is_write, input cfg_index_t idx,
                                input logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int reg_mask(input cfg_index_t idx);
        return (idx == CFG_BLINK_PERIOD) ? 'hFF : 'hFFF;
    endfunction

    task automatic verify_reg(input cfg_index_t idx);
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b0, idx, '0, rdata);
        if ((rdata & APB_DATA_W'(reg_mask(idx))) !== APB_DATA_W'(cfg_shadow[idx]))
            note_mismatch($sformatf("register %s read %0d, expected %0d", idx.name(),
                                    rdata, cfg_shadow[idx]));
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        logic [APB_DATA_W-1:0] rdata;
        apb_transfer(1'b1, idx, APB_DATA_W'(value), rdata);
        cfg_shadow[idx] = value & reg_mask(idx);
        verify_reg(idx);
    endtask

    task automatic load_config(input int threshold, input int margin, input int track,
                               input int goal, input int blink, input int top);
        write_reg(CFG_TURN_THRESHOLD, threshold);
        write_reg(CFG_LIGHT_MARGIN, margin);
        write_reg(CFG_TRACK_LEVEL, track);
        write_reg(CFG_GOAL_LEVEL, goal);
        write_reg(CFG_BLINK_PERIOD, blink);
        write_reg(CFG_TOP_SPEED, top);
    endtask

    // Waits until every item has gone in and every command has come out, and then
    // lets the pipeline settle, since readings that close no tick leave nothing to
    // wait for. Polling on the falling edge keeps clear of the driver's updates.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || sensor_ch.valid || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
    endtask

    task automatic queue_item(input int range_value, input bit last, input int ll,
                              input int lr);
        sensor_item_t it;
        it.range_reading = RANGE_W'(range_value);
        it.last_reading  = last;
        it.light_left    = LIGHT_W'(ll);
        it.light_right   = LIGHT_W'(lr);
        pending_items.push_back(it);
    endtask

    function automatic int clamp_light(input int x);
        return (x < 0) ? 0 : ((x > 4095) ? 4095 : x);
    endfunction

    // Light pairs placed around the current margin, tracking and goal levels, so
    // that both sides of every comparison are reached.
    task automatic pick_lights(input light_mode_t mode, output int ll, output int lr);
        int margin;
        int track;
        int goal;
        margin = cfg_shadow[CFG_LIGHT_MARGIN];
        track  = cfg_shadow[CFG_TRACK_LEVEL];
        goal   = cfg_shadow[CFG_GOAL_LEVEL];
        case (mode)
            LIGHTS_TOWARD_LEFT:
            begin
                lr = $urandom_range(clamp_light(track - 3), clamp_light(track + 40));
                ll = clamp_light(lr + margin + $urandom_range(0, 2));
            end
            LIGHTS_TOWARD_RIGHT:
            begin
                ll = $urandom_range(clamp_light(track - 3), clamp_light(track + 40));
                lr = clamp_light(ll + margin + $urandom_range(0, 2));
            end
            LIGHTS_DARK:
            begin
                ll = $urandom_range(0, track);
                lr = $urandom_range(0, track);
            end
            LIGHTS_NEAR_EQUAL:
            begin
                ll = $urandom_range(clamp_light(goal - 40), clamp_light(goal + 200));
                lr = clamp_light(ll + $urandom_range(0, 2 * margin + 2) - margin - 1);
            end
            default:
            begin
                ll = $urandom_range(0, 4095);
                lr = $urandom_range(0, 4095);
            end
        endcase
    endtask

    function automatic int pick_range(input range_mode_t mode, input int slot);
        case (mode)
            RANGES_CLEAR:
                return $urandom_range(0, 819);
            RANGES_LEFT_OBSTACLE:
                return (slot < 4) ? $urandom_range(700, 1024) : $urandom_range(0, 819);
            RANGES_RIGHT_OBSTACLE:
                return (slot >= 4 && slot < 8) ? $urandom_range(700, 1024)
                                               : $urandom_range(0, 819);
            RANGES_WILD:
                return $urandom_range(0, 2047);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 0;
                    1:       return 819;
                    2:       return 820;
                    3:       return 1024;
                    4:       return 2047;
                    default: return $urandom_range(810, 830);
                endcase
            end
        endcase
    endfunction

    // One control tick: mostly the usual eight sensors, sometimes a short tick and
    // sometimes more readings than there are weighted sensor slots.
    task automatic queue_tick(output int length);
        range_mode_t mode;
        light_mode_t lights;
        int          pick;
        int          ll;
        int          lr;
        pick = $urandom_range(99);
        if (pick < 55)
            length = 8;
        else if (pick < 85)
            length = $urandom_range(1, 16);
        else
            length = $urandom_range(17, 24);
        mode = range_mode_t'($urandom_range(0, 4));
        pick = $urandom_range(99);
        if (pick < 10)
            lights = LIGHTS_NEAR_EQUAL;
        else if (pick < 35)
            lights = LIGHTS_TOWARD_LEFT;
        else if (pick < 60)
            lights = LIGHTS_TOWARD_RIGHT;
        else if (pick < 75)
            lights = LIGHTS_DARK;
        else
            lights = LIGHTS_RANDOM;
        for (int slot = 0; slot < length - 1; slot++)
            queue_item(pick_range(mode, slot), 1'b0, $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
        pick_lights(lights, ll, lr);
        queue_item(pick_range(mode, length - 1), 1'b1, ll, lr);
    endtask

    task automatic queue_random(input int item_budget);
        int queued;
        int length;
        queued = 0;
        while (queued < item_budget)
        begin
            queue_tick(length);
            queued += length;
        end
    endtask

    initial
    begin
        // Every input of the block is known from time zero.
        rst_n                   = 1'b0;
        sensor_ch.valid         = 1'b0;
        sensor_ch.range_reading = '0;
        sensor_ch.last_reading  = 1'b0;
        sensor_ch.light_left    = '0;
        sensor_ch.light_right   = '0;
        steer_ch.ready          = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;

        cycle_count    = 0;
        mismatch_count = 0;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        set_idling(0, 0);

        // Register values after reset, and the reset state of the core.
        cfg_shadow[CFG_TURN_THRESHOLD] = 100;
        cfg_shadow[CFG_LIGHT_MARGIN]   = 5;
        cfg_shadow[CFG_TRACK_LEVEL]    = 600;
        cfg_shadow[CFG_GOAL_LEVEL]     = 890;
        cfg_shadow[CFG_BLINK_PERIOD]   = 70;
        cfg_shadow[CFG_TOP_SPEED]      = 2125;
        heading     = HEAD_FWD;
        sensor_slot = 0;
        left_sum    = 0;
        right_sum   = 0;
        blink_count = 0;
        led_index   = 0;
        led_on      = 1'b0;
        goal_hold   = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The registers must come out of reset with their documented values.
        for (int i = 0; i < CFG_REGS; i++)
            verify_reg(cfg_index_t'(i));

        // Directed ticks under the reset configuration. A lone closing item with no
        // obstacle drives straight on at full speed, with both lights at zero.
        queue_item(0, 1'b1, 0, 0);
        // Left sensors at the extremes and either side of the modifier knee; the
        // first reading alone is far above the limit, so the core turns left.
        queue_item(2047, 1'b0, 4095, 4095);
        queue_item(1024, 1'b0, 4095, 4095);
        queue_item(820, 1'b0, 4095, 4095);
        queue_item(819, 1'b0, 4095, 4095);
        for (int i = 0; i < 3; i++)
            queue_item(0, 1'b0, 4095, 4095);
        queue_item(0, 1'b1, 100, 100);
        // Still blocked while turning left: the slower 0.8 turn. The brighter left
        // light is ignored because the dimmer one is below the tracking level.
        queue_item(1024, 1'b1, 200, 100);
        // A reading just below the knee adds nothing, so the way is clear again.
        queue_item(819, 1'b1, 0, 0);
        // An obstacle on the right-hand sensors turns right.
        for (int i = 0; i < 4; i++)
            queue_item(0, 1'b0, 0, 0);
        queue_item(1024, 1'b1, 0, 0);
        // Any obstacle keeps the right turn going; then the way clears.
        queue_item(2047, 1'b1, 0, 0);
        queue_item(0, 1'b1, 0, 0);
        // Light tracking to each side, then a difference of exactly the margin,
        // which does not count as tracking.
        queue_item(0, 1'b1, 1000, 700);
        queue_item(0, 1'b1, 700, 1000);
        queue_item(0, 1'b1, 705, 700);
        // One light exactly at the goal level: the goal is not reached.
        queue_item(0, 1'b1, 895, 890);
        wait_idle();

        // Lowest settings: every positive sum is an obstacle, the LED advances on each
        // heading-machine decision, and the goal level is out of reach until the last phases.
        load_config(0, 0, 0, 4095, 1, 4095);
        queue_random(225);
        wait_idle();

        // Highest settings with a gappy sender: no obstacle can ever be seen and
        // the wheels are stopped.
        set_idling(51, 0);
        load_config(4095, 4095, 4095, 4095, 255, 0);
        queue_random(225);
        wait_idle();

        // A stalling receiver, opened with one long hold-off so that commands back
        // up and the sensor channel has to stop.
        set_idling(0, 51);
        load_config($urandom_range(20, 300), $urandom_range(0, 50), $urandom_range(0, 1500),
                    4095, $urandom_range(30, 60), $urandom_range(1, 4095));
        hold_requests++;
        queue_random(225);
        wait_idle();

        // Both sides idle at random; halfway through, the sender waits until every
        // command has come out before it carries on.
        set_idling(25, 25);
        load_config($urandom_range(0, 600), $urandom_range(0, 200), $urandom_range(0, 4095),
                    4095, $urandom_range(2, 5), $urandom_range(0, 4095));
        queue_random(115);
        wait_idle();
        queue_random(115);
        wait_idle();

        // Back to the usual levels with the goal in reach; near-equal bright lights
        // sooner or later latch the goal, after which every tick stops the robot.
        load_config(100, 5, 600, 890, 3, 2125);
        queue_random(250);
        wait_idle();

        // With the goal level at zero the latch is certain if it has not yet
        // happened, and a zero blink period must not disturb the latched answer.
        set_idling(0, 0);
        load_config($urandom_range(0, 4095), $urandom_range(0, 50), $urandom_range(0, 4095),
                    0, 0, $urandom_range(0, 4095));
        queue_random(150);
        wait_idle();

        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
design/lsoa_pkg.sv
design/lsoa_in_if.sv
design/lsoa_out_if.sv
design/light_seek_obstacle_avoid_steering.sv
tb/sv/light_seek_obstacle_avoid_steering_test.sv
